[rtl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants of the accumulator cpu step core: memory size,
// opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package acs_pkg;

    // word memory, program and data share it
    localparam int unsigned MEM_WORDS = 65536;
    localparam int          MEM_AW    = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

    localparam int          PROG_LEN_W   = 17;
    localparam int          OPERAND_SHIFT = 8;
    localparam logic [7:0]  OPCODE_LAST  = 8'd18;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // configuration register index, taken from paddr[2]
    localparam logic REG_PROG_LEN = 1'b0;

    typedef enum logic [7:0] {
        OP_LDC  = 8'd0,
        OP_ADC  = 8'd1,
        OP_LDL  = 8'd2,
        OP_STL  = 8'd3,
        OP_LDNL = 8'd4,
        OP_STNL = 8'd5,
        OP_ADD  = 8'd6,
        OP_SUB  = 8'd7,
        OP_SHL  = 8'd8,
        OP_SHR  = 8'd9,
        OP_ADJ  = 8'd10,
        OP_A2SP = 8'd11,
        OP_SP2A = 8'd12,
        OP_CALL = 8'd13,
        OP_RET  = 8'd14,
        OP_BRZ  = 8'd15,
        OP_BRLZ = 8'd16,
        OP_BR   = 8'd17,
        OP_HALT = 8'd18
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_HALTED     = 3'd1,
        STAT_PC_FAULT   = 3'd2,
        STAT_BAD_OP     = 3'd3,
        STAT_ADDR_FAULT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DONE,
        ST_EXEC,
        ST_LOAD
    } fsm_state_t;

endpackage

[rtl/accumulator_cpu_step_core.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_step_core
// Small accumulator processor (A, B, PC, SP, step count) around one
// single-port synchronous word memory, one transaction per item.
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall): mode 0 writes data to the word at
//   address, mode 1 executes one instruction from the word at the pc.
//   result channel (result_valid / result_stall): one transaction per item
//   with the status and the registers after that item.
//   apb port: register 0 (byte address 0) holds the program length.
// result path: a write passes the done state, a step the execute state, before
//   its result is registered; a load (ldl, ldnl) also passes the load state.
// throughput: while results are not stalled, writes and register-only steps go
//   one per cycle; a load or a store holds the item channel in execute, since
//   the fetch, the data read and the store all go through the one memory port.
// the pc of a step taken in the last cycle of a branch is forwarded straight
//   to the fetch address.
// reset clears the registers, the pc, the step count and the program length;
//   the word memory has no reset and must be written before it is fetched.
// a stalled result holds in the output register; the item in progress then
//   waits with its result, and while it waits no further item is taken.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic               mode,
    input  logic [15:0]        address,
    input  logic signed [31:0] data,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         status,
    output logic signed [31:0] acc_a,
    output logic signed [31:0] acc_b,
    output logic signed [31:0] prog_counter,
    output logic signed [31:0] stack_ptr,
    output logic [31:0]        executed_count,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // architectural state
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [acs_pkg::PROG_LEN_W-1:0] prog_len_reg;

    acs_pkg::fsm_state_t state_reg, state_next;
    acs_pkg::status_t    done_status_reg, done_status_next;
    logic                ldl_reg, ldl_next;

    // output register
    logic               res_valid_reg, res_valid_next;
    acs_pkg::status_t   res_status_reg;
    logic [31:0]        res_a_reg, res_b_reg, res_pc_reg, res_sp_reg, res_cnt_reg;

    // word memory
    logic [31:0] word_mem [acs_pkg::MEM_WORDS];
    logic [31:0] mem_rdata_reg;
    logic        mem_we, mem_re;
    logic [acs_pkg::MEM_AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    // execute stage candidates
    logic [31:0]      ex_a, ex_b, ex_pc, ex_sp, ex_cnt;
    acs_pkg::status_t ex_status;
    logic             ex_load, ex_store, ex_ldl;
    logic [31:0]      ex_daddr, ex_wdata;

    // handshake and control
    logic        out_free, finish, port_busy, accept_ok, take, leave_exec;
    logic        cfg_write;
    logic [31:0] wr_addr32;
    logic        wr_in_range;
    acs_pkg::status_t fin_status;
    logic [31:0] fin_a, fin_b, fin_pc, fin_sp, fin_cnt;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == acs_pkg::REG_PROG_LEN))
        begin
            prog_len_reg <= pwdata[acs_pkg::PROG_LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == acs_pkg::REG_PROG_LEN)
        begin
            prdata = {{(32 - acs_pkg::PROG_LEN_W){1'b0}}, prog_len_reg};
        end
    end

    // ------------------------------------------------------------------
    // execute: decode the fetched word and work out the new state
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]  op;
        logic [31:0] opr;
        logic [31:0] base;
        logic        pc_fault;
        logic        big_shift;

        op        = mem_rdata_reg[7:0];
        opr       = {{acs_pkg::OPERAND_SHIFT{mem_rdata_reg[31]}},
                     mem_rdata_reg[31:acs_pkg::OPERAND_SHIFT]};
        pc_fault  = (pc_reg >= {{(32 - acs_pkg::PROG_LEN_W){1'b0}}, prog_len_reg})
                 || (pc_reg >= acs_pkg::MEM_LIMIT);
        big_shift = |a_reg[31:5];
        base      = (op == acs_pkg::OP_LDL || op == acs_pkg::OP_STL) ? sp_reg : a_reg;

        ex_a      = a_reg;
        ex_b      = b_reg;
        ex_pc     = pc_reg + 32'd1;
        ex_sp     = sp_reg;
        ex_cnt    = cnt_reg + 32'd1;
        ex_status = acs_pkg::STAT_OK;
        ex_load   = 1'b0;
        ex_store  = 1'b0;
        ex_ldl    = 1'b0;
        ex_daddr  = base + opr;
        ex_wdata  = a_reg;

        if (pc_fault)
        begin
            ex_pc     = pc_reg;
            ex_cnt    = cnt_reg;
            ex_status = acs_pkg::STAT_PC_FAULT;
        end
        else
        begin
            case (acs_pkg::opcode_t'(op))
                acs_pkg::OP_LDC:
                begin
                    ex_b = a_reg;
                    ex_a = opr;
                end
                acs_pkg::OP_ADC:  ex_a = a_reg + opr;
                acs_pkg::OP_LDL, acs_pkg::OP_LDNL,
                acs_pkg::OP_STL, acs_pkg::OP_STNL:
                begin
                    if (ex_daddr >= acs_pkg::MEM_LIMIT)
                    begin
                        ex_pc     = pc_reg;
                        ex_status = acs_pkg::STAT_ADDR_FAULT;
                    end
                    else if (op == acs_pkg::OP_LDL || op == acs_pkg::OP_LDNL)
                    begin
                        // register update finishes in the load state
                        ex_load = 1'b1;
                        ex_ldl  = (op == acs_pkg::OP_LDL);
                    end
                    else if (op == acs_pkg::OP_STL)
                    begin
                        ex_store = 1'b1;
                        ex_wdata = a_reg;
                        ex_a     = b_reg;
                    end
                    else
                    begin
                        ex_store = 1'b1;
                        ex_wdata = b_reg;
                    end
                end
                acs_pkg::OP_ADD:  ex_a = b_reg + a_reg;
                acs_pkg::OP_SUB:  ex_a = b_reg - a_reg;
                acs_pkg::OP_SHL:  ex_a = big_shift ? 32'd0 : (b_reg << a_reg[4:0]);
                acs_pkg::OP_SHR:  ex_a = big_shift ? {32{b_reg[31]}}
                                                   : 32'($signed(b_reg) >>> a_reg[4:0]);
                acs_pkg::OP_ADJ:  ex_sp = sp_reg + opr;
                acs_pkg::OP_A2SP:
                begin
                    ex_sp = a_reg;
                    ex_a  = b_reg;
                end
                acs_pkg::OP_SP2A:
                begin
                    ex_b = a_reg;
                    ex_a = sp_reg;
                end
                acs_pkg::OP_CALL:
                begin
                    ex_b  = a_reg;
                    ex_a  = pc_reg;
                    ex_pc = opr;
                end
                acs_pkg::OP_RET:
                begin
                    ex_pc = a_reg + 32'd1;
                    ex_a  = b_reg;
                end
                acs_pkg::OP_BRZ:
                begin
                    if (a_reg == 32'd0)
                    begin
                        ex_pc = pc_reg + 32'd1 + opr;
                    end
                end
                acs_pkg::OP_BRLZ:
                begin
                    if (a_reg[31])
                    begin
                        ex_pc = pc_reg + 32'd1 + opr;
                    end
                end
                acs_pkg::OP_BR:   ex_pc = pc_reg + 32'd1 + opr;
                acs_pkg::OP_HALT:
                begin
                    ex_pc     = pc_reg;
                    ex_status = acs_pkg::STAT_HALTED;
                end
                default:
                begin
                    // opcodes past halt: counted, nothing else
                    ex_pc     = pc_reg;
                    ex_status = acs_pkg::STAT_BAD_OP;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and memory port control
    // ------------------------------------------------------------------
    assign out_free   = !res_valid_reg || !result_stall;
    assign finish     = out_free && ((state_reg == acs_pkg::ST_DONE)
                     || (state_reg == acs_pkg::ST_LOAD)
                     || ((state_reg == acs_pkg::ST_EXEC) && !ex_load));
    assign port_busy  = (state_reg == acs_pkg::ST_EXEC) && ex_store;
    assign accept_ok  = (state_reg == acs_pkg::ST_IDLE) || (finish && !port_busy);
    assign item_stall = !accept_ok;
    assign take       = item_valid && accept_ok;
    assign leave_exec = (state_reg == acs_pkg::ST_EXEC) && (finish || ex_load);

    assign wr_addr32   = {16'd0, address};
    assign wr_in_range = wr_addr32 < acs_pkg::MEM_LIMIT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if ((state_reg == acs_pkg::ST_EXEC) && ex_load)
        begin
            state_next = acs_pkg::ST_LOAD;
        end
        else if (take)
        begin
            state_next = (mode == acs_pkg::MODE_STEP) ? acs_pkg::ST_EXEC : acs_pkg::ST_DONE;
        end
        else if (finish)
        begin
            state_next = acs_pkg::ST_IDLE;
        end
    end

    // outputs of the controller and datapath updates
    always_comb
    begin
        fin_status = done_status_reg;
        fin_a      = a_reg;
        fin_b      = b_reg;
        fin_pc     = pc_reg;
        fin_sp     = sp_reg;
        fin_cnt    = cnt_reg;

        case (state_reg)
            acs_pkg::ST_EXEC:
            begin
                fin_status = ex_status;
                fin_a      = ex_a;
                fin_b      = ex_b;
                fin_pc     = ex_pc;
                fin_sp     = ex_sp;
                fin_cnt    = ex_cnt;
            end
            acs_pkg::ST_LOAD:
            begin
                fin_status = acs_pkg::STAT_OK;
                fin_a      = mem_rdata_reg;
                fin_b      = ldl_reg ? a_reg : b_reg;
                fin_pc     = pc_reg + 32'd1;
            end
            default:
            begin
                fin_status = done_status_reg;
            end
        endcase

        a_next  = a_reg;
        b_next  = b_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        cnt_next = cnt_reg;
        if (finish)
        begin
            a_next   = fin_a;
            b_next   = fin_b;
            pc_next  = fin_pc;
            sp_next  = fin_sp;
            cnt_next = fin_cnt;
        end
        else if (leave_exec)
        begin
            // load issued: only the count moves now
            cnt_next = ex_cnt;
        end

        ldl_next = ldl_reg;
        if (leave_exec && ex_load)
        begin
            ldl_next = ex_ldl;
        end

        done_status_next = done_status_reg;
        if (take && (mode == acs_pkg::MODE_WRITE))
        begin
            done_status_next = wr_in_range ? acs_pkg::STAT_OK : acs_pkg::STAT_ADDR_FAULT;
        end

        res_valid_next = finish ? 1'b1 : (out_free ? 1'b0 : res_valid_reg);

        // one port: write item, fetch, data read or store
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pc_next[acs_pkg::MEM_AW-1:0];
        mem_wdata = $unsigned(data);
        if (take && (mode == acs_pkg::MODE_WRITE))
        begin
            mem_we   = wr_in_range;
            mem_addr = wr_addr32[acs_pkg::MEM_AW-1:0];
        end
        else if (take)
        begin
            // fetch at the pc this edge leaves behind
            mem_re   = 1'b1;
            mem_addr = pc_next[acs_pkg::MEM_AW-1:0];
        end
        else if ((state_reg == acs_pkg::ST_EXEC) && ex_load)
        begin
            mem_re   = 1'b1;
            mem_addr = ex_daddr[acs_pkg::MEM_AW-1:0];
        end
        else if (port_busy && finish)
        begin
            mem_we    = 1'b1;
            mem_addr  = ex_daddr[acs_pkg::MEM_AW-1:0];
            mem_wdata = ex_wdata;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= acs_pkg::ST_IDLE;
            a_reg           <= '0;
            b_reg           <= '0;
            pc_reg          <= '0;
            sp_reg          <= '0;
            cnt_reg         <= '0;
            ldl_reg         <= 1'b0;
            done_status_reg <= acs_pkg::STAT_OK;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            pc_reg          <= pc_next;
            sp_reg          <= sp_next;
            cnt_reg         <= cnt_next;
            ldl_reg         <= ldl_next;
            done_status_reg <= done_status_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_status_reg <= fin_status;
            res_a_reg      <= fin_a;
            res_b_reg      <= fin_b;
            res_pc_reg     <= fin_pc;
            res_sp_reg     <= fin_sp;
            res_cnt_reg    <= fin_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            mem_rdata_reg <= word_mem[mem_addr];
        end
    end

    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign acc_a          = $signed(res_a_reg);
    assign acc_b          = $signed(res_b_reg);
    assign prog_counter   = $signed(res_pc_reg);
    assign stack_ptr      = $signed(res_sp_reg);
    assign executed_count = res_cnt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_step_goes_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        take && (mode == acs_pkg::MODE_STEP) |=> state_reg == acs_pkg::ST_EXEC)
        else $error("accepted step did not enter execute");

    a_count_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(state_reg) == acs_pkg::ST_EXEC)
        else $error("step count moved outside execute");

    a_load_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acs_pkg::ST_LOAD) |->
            ($past(state_reg) == acs_pkg::ST_EXEC || $past(state_reg) == acs_pkg::ST_LOAD))
        else $error("load state entered without a data read");

    a_one_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

endmodule
